FILE: hw/rtl/ahe_pkg.sv
// ----------------------------------------------------------------------------
// ahe_pkg: shared types and constants for the adaptive Huffman encoder
// Tree sizes, node word layout and sequencer states.
// ----------------------------------------------------------------------------
package ahe_pkg;

  localparam int LETTERS     = 52;
  localparam int NODE_COUNT  = 103;
  localparam int WEIGHT_BITS = 32;

  localparam int TOP       = NODE_COUNT - 1;
  localparam int CODE_MAX  = 58;
  localparam int LEN_W     = 6;
  localparam int NODE_AW   = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);
  localparam int LETTER_AW = $clog2(LETTERS);

  // ASCII ranges and escape code split
  localparam int UPPER_LO   = 65;
  localparam int UPPER_HI   = 90;
  localparam int LOWER_LO   = 97;
  localparam int LOWER_HI   = 122;
  localparam int LOWER_BASE = 71;
  localparam int ESC_SPLIT  = 40;
  localparam int ESC_OFFSET = 20;
  localparam int ESC_LONG   = 6;
  localparam int ESC_SHORT  = 5;

  // one tree position: weight, leaf flag, right child or letter
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic                   leaf;
    logic [NODE_AW-1:0]     child;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_PQ, S_PQW, S_PCW, S_ESC, S_EMIT,
    S_SPLIT, S_SPLIT2, S_SPLIT3,
    S_UP, S_UPR, S_SCAN, S_DECIDE, S_SWAP2, S_FIX, S_PAR, S_PARW,
    S_ROOTINC, S_ROOTW
  } state_t;

endpackage

FILE: hw/rtl/ahe_if.sv
// ----------------------------------------------------------------------------
// ahe_if: valid/ready channels of the adaptive Huffman encoder
// Symbol channel in, code channel out.
// ----------------------------------------------------------------------------
interface ahe_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_byte;

  modport source (output valid, output symbol_byte, input ready);
  modport sink   (input valid, input symbol_byte, output ready);
endinterface

interface ahe_code_if;
  logic                             valid;
  logic                             ready;
  logic [ahe_pkg::CODE_MAX-1:0]     code_bits;
  logic [ahe_pkg::LEN_W-1:0]        code_length;
  logic                             new_letter;
  logic                             bad_symbol;
  logic                             weight_overflow;

  modport source (output valid, output code_bits, output code_length,
                  output new_letter, output bad_symbol, output weight_overflow,
                  input ready);
  modport sink   (input valid, input code_bits, input code_length,
                  input new_letter, input bad_symbol, input weight_overflow,
                  output ready);
endinterface

FILE: hw/rtl/adaptive_huffman_encoder_unit.sv
// ----------------------------------------------------------------------------
// adaptive_huffman_encoder_unit: FGK adaptive Huffman encoder, 52 letters
// Codes one letter per beat and updates the tree under a small sequencer.
//
//   channel | dir | payload
//   sym     | in  | symbol_byte
//   code    | out | code_bits, code_length, new_letter, bad_symbol,
//           |     | weight_overflow
//
// A symbol is coded by walking from its leaf, or the NYT leaf, to the root.
// Each updated level then runs a leader scan, plus a swap and relink when a
// leader is found; a new letter splits the NYT leaf first, and the root weight
// is incremented last. sym.ready is high only between symbols.
// Reset (rst, synchronous) clears valid bits at once; no clearing pass.
// A stalled code beat holds its register; the next result waits for it.
// ----------------------------------------------------------------------------
module adaptive_huffman_encoder_unit (
  input  logic      clk,
  input  logic      rst,
  ahe_sym_if.sink   sym,
  ahe_code_if.source code
);

  localparam int NW = $bits(ahe_pkg::node_t);

  ahe_pkg::state_t state, state_next;

  // RAM ports
  logic                           node_we, par_we, let_we;
  logic [ahe_pkg::NODE_AW-1:0]    node_wa, par_wa, node_ra, par_ra;
  logic [ahe_pkg::NODE_AW-1:0]    par_wd, let_wd;
  logic [ahe_pkg::LETTER_AW-1:0]  let_wa, let_ra;
  ahe_pkg::node_t                 node_wd, node_rd;
  logic [NW-1:0]                  node_q;
  logic [ahe_pkg::NODE_AW-1:0]    par_q, par_rd, let_q, let_rd;
  logic [ahe_pkg::NODE_AW-1:0]    node_ra_q, par_ra_q;
  logic [ahe_pkg::LETTER_AW-1:0]  let_ra_q;
  logic [ahe_pkg::NODE_COUNT-1:0] node_vld, par_vld;
  logic [ahe_pkg::LETTERS-1:0]    let_vld;

  // sequencer registers
  logic [ahe_pkg::LETTER_AW-1:0]   idx, idx_next;
  logic                            bad, bad_next, ovf, ovf_next, fresh, fresh_next;
  logic [ahe_pkg::NODE_AW-1:0]     ln, ln_next, q, q_next, p, p_next;
  logic [ahe_pkg::NODE_AW-1:0]     nyt, nyt_next, pp, pp_next, lead, lead_next;
  logic [ahe_pkg::NODE_AW-1:0]     cp, cp_next, cl, cl_next, i, i_next, iq, iq_next;
  logic [ahe_pkg::CNT_W-1:0]       steps, steps_next;
  logic [ahe_pkg::CODE_MAX-1:0]    code_r, code_next;
  logic [ahe_pkg::LEN_W-1:0]       len, len_next;
  logic [ahe_pkg::WEIGHT_BITS-1:0] wp, wp_next;
  logic                            lp, lp_next, ll, ll_next;
  logic                            pend, pend_next, fix_b, fix_b_next, fix_ph, fix_ph_next;
  logic                            out_load;

  // input decode
  logic [7:0]                     b;
  logic                           dec_bad;
  logic [7:0]                     dec_idx;
  // fix-up and escape helpers
  logic [ahe_pkg::NODE_AW-1:0]    fx_x, fx_c;
  logic                           fx_leaf, fx_two;
  logic [ahe_pkg::CODE_MAX-1:0]   esc_code;
  logic [ahe_pkg::LEN_W:0]        esc_len;
  logic [5:0]                     esc_val;

  // memories
  ahe_ram #(.WIDTH(NW), .DEPTH(ahe_pkg::NODE_COUNT)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_q)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_AW), .DEPTH(ahe_pkg::NODE_COUNT)) u_par_ram (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
    .raddr(par_ra), .rdata(par_q)
  );
  ahe_ram #(.WIDTH(ahe_pkg::NODE_AW), .DEPTH(ahe_pkg::LETTERS)) u_let_ram (
    .clk(clk), .we(let_we), .waddr(let_wa), .wdata(let_wd),
    .raddr(let_ra), .rdata(let_q)
  );

  // valid bits and read address tracking
  always_ff @(posedge clk) begin
    node_ra_q <= node_ra;
    par_ra_q  <= par_ra;
    let_ra_q  <= let_ra;
    if (rst) begin
      node_vld <= '0;
      par_vld  <= '0;
      let_vld  <= '0;
    end else begin
      if (node_we) node_vld[node_wa] <= 1'b1;
      if (par_we)  par_vld[par_wa]   <= 1'b1;
      if (let_we)  let_vld[let_wa]   <= 1'b1;
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (node_vld[node_ra_q]) begin
      node_rd = ahe_pkg::node_t'(node_q);
    end else begin
      node_rd.weight = '0;
      node_rd.leaf   = (int'(node_ra_q) == ahe_pkg::TOP);
      node_rd.child  = '0;
    end
    par_rd = par_vld[par_ra_q] ? par_q : '0;
    let_rd = let_vld[let_ra_q] ? let_q : '0;
  end

  // letter decode
  always_comb begin
    b       = sym.symbol_byte;
    dec_bad = 1'b0;
    dec_idx = 8'hff;
    if (b >= 8'(ahe_pkg::UPPER_LO) && b <= 8'(ahe_pkg::UPPER_HI)) begin
      dec_idx = b - 8'(ahe_pkg::UPPER_LO);
    end else if (b >= 8'(ahe_pkg::LOWER_LO) && b <= 8'(ahe_pkg::LOWER_HI)) begin
      dec_idx = b - 8'(ahe_pkg::LOWER_BASE);
    end
    if (int'(dec_idx) >= ahe_pkg::LETTERS) dec_bad = 1'b1;
  end

  // escape append
  always_comb begin
    if (int'(idx) < ahe_pkg::ESC_SPLIT) begin
      esc_val  = 6'(idx);
      esc_code = (code_r << ahe_pkg::ESC_LONG) | ahe_pkg::CODE_MAX'(esc_val);
      esc_len  = (ahe_pkg::LEN_W+1)'(len) + (ahe_pkg::LEN_W+1)'(ahe_pkg::ESC_LONG);
    end else begin
      esc_val  = 6'(idx) - 6'(ahe_pkg::ESC_OFFSET);
      esc_code = (code_r << ahe_pkg::ESC_SHORT) | ahe_pkg::CODE_MAX'(esc_val);
      esc_len  = (ahe_pkg::LEN_W+1)'(len) + (ahe_pkg::LEN_W+1)'(ahe_pkg::ESC_SHORT);
    end
  end

  // link fix-up operands: first the old position, then the leader
  always_comb begin
    fx_x    = fix_b ? lead : p;
    fx_leaf = fix_b ? lp : ll;
    fx_c    = fix_b ? cp : cl;
    fx_two  = !fx_leaf && fx_c != '0 && int'(fx_c) < ahe_pkg::NODE_COUNT;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    idx_next = idx; bad_next = bad; ovf_next = ovf; fresh_next = fresh;
    ln_next = ln; q_next = q; p_next = p; nyt_next = nyt; pp_next = pp;
    lead_next = lead; cp_next = cp; cl_next = cl; i_next = i; iq_next = iq;
    steps_next = steps; code_next = code_r; len_next = len; wp_next = wp;
    lp_next = lp; ll_next = ll; pend_next = pend; fix_b_next = fix_b;
    fix_ph_next = fix_ph;
    out_load = 1'b0;
    node_we = 1'b0; node_wa = '0; node_wd = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0;
    let_we = 1'b0; let_wa = '0; let_wd = '0;
    node_ra = '0; par_ra = '0; let_ra = '0;
    sym.ready = (state == ahe_pkg::S_IDLE);

    case (state)
      ahe_pkg::S_IDLE: begin
        node_ra = ahe_pkg::NODE_AW'(ahe_pkg::TOP);
        let_ra  = ahe_pkg::LETTER_AW'(dec_idx);
        if (sym.valid) begin
          idx_next   = ahe_pkg::LETTER_AW'(dec_idx);
          bad_next   = dec_bad;
          ovf_next   = 1'b0;
          fresh_next = 1'b0;
          code_next  = '0;
          len_next   = '0;
          steps_next = '0;
          state_next = dec_bad ? ahe_pkg::S_EMIT : ahe_pkg::S_ROOT;
        end
      end
      ahe_pkg::S_ROOT: begin
        ovf_next   = (node_rd.weight == '1);
        fresh_next = (let_rd == '0);
        ln_next    = let_rd;
        q_next     = (let_rd == '0) ? nyt : let_rd;
        state_next = ahe_pkg::S_PQ;
      end
      // walk leaf to root collecting path bits
      ahe_pkg::S_PQ: begin
        par_ra = q;
        if (int'(q) == ahe_pkg::TOP || int'(q) >= ahe_pkg::NODE_COUNT ||
            int'(steps) >= ahe_pkg::NODE_COUNT) begin
          state_next = ahe_pkg::S_ESC;
        end else begin
          state_next = ahe_pkg::S_PQW;
        end
      end
      ahe_pkg::S_PQW: begin
        node_ra = par_rd;
        p_next  = par_rd;
        state_next = (int'(par_rd) >= ahe_pkg::NODE_COUNT) ? ahe_pkg::S_ESC
                                                           : ahe_pkg::S_PCW;
      end
      ahe_pkg::S_PCW: begin
        if (int'(len) < ahe_pkg::CODE_MAX) begin
          code_next = code_r | (ahe_pkg::CODE_MAX'(node_rd.child == q) << len);
          len_next  = len + 1'b1;
        end
        q_next     = p;
        steps_next = steps + 1'b1;
        state_next = ahe_pkg::S_PQ;
      end
      ahe_pkg::S_ESC: begin
        if (fresh) begin
          code_next = esc_code;
          len_next  = (int'(esc_len) > ahe_pkg::CODE_MAX) ?
                      ahe_pkg::LEN_W'(ahe_pkg::CODE_MAX) : ahe_pkg::LEN_W'(esc_len);
        end
        state_next = ahe_pkg::S_EMIT;
      end
      // hand the result over, then update the tree (skipped for a bad symbol, a weight overflow or a full tree)
      ahe_pkg::S_EMIT: begin
        node_ra = nyt;
        if (!code.valid || code.ready) begin
          out_load   = 1'b1;
          steps_next = '0;
          p_next     = ln;
          if (bad || ovf) begin
            state_next = ahe_pkg::S_IDLE;
          end else if (!fresh) begin
            state_next = ahe_pkg::S_UP;
          end else if (nyt >= ahe_pkg::NODE_AW'(2)) begin
            state_next = ahe_pkg::S_SPLIT;
          end else begin
            state_next = ahe_pkg::S_IDLE;
          end
        end
      end
      // split the NYT leaf
      ahe_pkg::S_SPLIT: begin
        node_we = 1'b1; node_wa = nyt;
        node_wd.weight = node_rd.weight; node_wd.leaf = 1'b0;
        node_wd.child = nyt - 1'b1;
        par_we = 1'b1; par_wa = nyt - 1'b1; par_wd = nyt;
        let_we = 1'b1; let_wa = idx; let_wd = nyt - 1'b1;
        state_next = ahe_pkg::S_SPLIT2;
      end
      ahe_pkg::S_SPLIT2: begin
        node_we = 1'b1; node_wa = nyt - 1'b1;
        node_wd.weight = '0; node_wd.leaf = 1'b1;
        node_wd.child = ahe_pkg::NODE_AW'(idx);
        par_we = 1'b1; par_wa = nyt - ahe_pkg::NODE_AW'(2); par_wd = nyt;
        state_next = ahe_pkg::S_SPLIT3;
      end
      ahe_pkg::S_SPLIT3: begin
        node_we = 1'b1; node_wa = nyt - ahe_pkg::NODE_AW'(2);
        node_wd.weight = '0; node_wd.leaf = 1'b1; node_wd.child = '0;
        nyt_next   = nyt - ahe_pkg::NODE_AW'(2);
        p_next     = nyt - 1'b1;
        state_next = ahe_pkg::S_UP;
      end
      // weight update, one level per pass
      ahe_pkg::S_UP: begin
        node_ra = p;
        par_ra  = p;
        if (int'(p) == ahe_pkg::TOP || int'(p) >= ahe_pkg::NODE_COUNT ||
            int'(steps) >= ahe_pkg::NODE_COUNT) begin
          state_next = ahe_pkg::S_ROOTINC;
        end else begin
          state_next = ahe_pkg::S_UPR;
        end
      end
      ahe_pkg::S_UPR: begin
        wp_next   = node_rd.weight;
        lp_next   = node_rd.leaf;
        cp_next   = node_rd.child;
        pp_next   = par_rd;
        lead_next = p;
        i_next    = p + 1'b1;
        pend_next = 1'b0;
        state_next = ahe_pkg::S_SCAN;
      end
      // leader scan: one read issued and one compare per cycle
      ahe_pkg::S_SCAN: begin
        node_ra = i;
        if (pend && node_rd.weight == wp && iq != pp) begin
          lead_next = iq;
          ll_next   = node_rd.leaf;
          cl_next   = node_rd.child;
        end
        if (int'(i) < ahe_pkg::TOP) begin
          iq_next   = i;
          i_next    = i + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = ahe_pkg::S_DECIDE;
        end
      end
      ahe_pkg::S_DECIDE: begin
        node_we = 1'b1; node_wa = p;
        if (lead != p) begin
          node_wd.weight = wp; node_wd.leaf = ll; node_wd.child = cl;
          if (p == nyt) nyt_next = lead;
          else if (lead == nyt) nyt_next = p;
          state_next = ahe_pkg::S_SWAP2;
        end else begin
          node_wd.weight = wp + 1'b1; node_wd.leaf = lp; node_wd.child = cp;
          p_next     = pp;
          steps_next = steps + 1'b1;
          state_next = ahe_pkg::S_UP;
        end
      end
      ahe_pkg::S_SWAP2: begin
        node_we = 1'b1; node_wa = lead;
        node_wd.weight = wp + 1'b1; node_wd.leaf = lp; node_wd.child = cp;
        fix_b_next  = 1'b0;
        fix_ph_next = 1'b0;
        state_next  = ahe_pkg::S_FIX;
      end
      // relink letters or children of both swapped positions
      ahe_pkg::S_FIX: begin
        if (fx_leaf) begin
          if (fx_x != nyt && int'(fx_c) < ahe_pkg::LETTERS) begin
            let_we = 1'b1; let_wa = ahe_pkg::LETTER_AW'(fx_c); let_wd = fx_x;
          end
        end else if (fx_two) begin
          par_we = 1'b1;
          par_wa = fix_ph ? fx_c - 1'b1 : fx_c;
          par_wd = fx_x;
        end
        if (fx_two && !fix_ph) begin
          fix_ph_next = 1'b1;
        end else begin
          fix_ph_next = 1'b0;
          fix_b_next  = 1'b1;
          if (fix_b) state_next = ahe_pkg::S_PAR;
        end
      end
      ahe_pkg::S_PAR: begin
        par_ra     = lead;
        state_next = ahe_pkg::S_PARW;
      end
      ahe_pkg::S_PARW: begin
        p_next     = par_rd;
        steps_next = steps + 1'b1;
        state_next = ahe_pkg::S_UP;
      end
      ahe_pkg::S_ROOTINC: begin
        node_ra    = ahe_pkg::NODE_AW'(ahe_pkg::TOP);
        state_next = ahe_pkg::S_ROOTW;
      end
      ahe_pkg::S_ROOTW: begin
        node_we = 1'b1; node_wa = ahe_pkg::NODE_AW'(ahe_pkg::TOP);
        node_wd.weight = node_rd.weight + 1'b1;
        node_wd.leaf   = node_rd.leaf;
        node_wd.child  = node_rd.child;
        state_next = ahe_pkg::S_IDLE;
      end
      default: state_next = ahe_pkg::S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ahe_pkg::S_IDLE;
      nyt    <= ahe_pkg::NODE_AW'(ahe_pkg::TOP);
      pend   <= 1'b0;
      fix_b  <= 1'b0;
      fix_ph <= 1'b0;
    end else begin
      state  <= state_next;
      nyt    <= nyt_next;
      pend   <= pend_next;
      fix_b  <= fix_b_next;
      fix_ph <= fix_ph_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx <= idx_next; bad <= bad_next; ovf <= ovf_next; fresh <= fresh_next;
    ln <= ln_next; q <= q_next; p <= p_next; pp <= pp_next; lead <= lead_next;
    cp <= cp_next; cl <= cl_next; i <= i_next; iq <= iq_next;
    steps <= steps_next; code_r <= code_next; len <= len_next; wp <= wp_next;
    lp <= lp_next; ll <= ll_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      code.valid <= 1'b0;
    end else if (out_load) begin
      code.valid <= 1'b1;
    end else if (code.ready) begin
      code.valid <= 1'b0;
    end
    if (out_load) begin
      code.code_bits       <= code_r;
      code.code_length     <= len;
      code.new_letter      <= fresh;
      code.bad_symbol      <= bad;
      code.weight_overflow <= ovf;
    end
  end

`ifndef NO_ASSERTIONS
  a_nyt_range: assert property (@(posedge clk) disable iff (rst)
    int'(nyt) < ahe_pkg::NODE_COUNT)
    else $error("NYT position out of range");
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    code.valid && code.bad_symbol |-> code.code_length == '0 && !code.new_letter)
    else $error("bad symbol beat carries a code");
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    code.valid |-> int'(code.code_length) <= ahe_pkg::CODE_MAX)
    else $error("code length above maximum");
  a_lead_order: assert property (@(posedge clk) disable iff (rst)
    state == ahe_pkg::S_DECIDE |-> lead >= p)
    else $error("leader below current node");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sym.valid && sym.ready |=> !sym.ready)
    else $error("accepted two symbols back to back");
`endif

endmodule

FILE: hw/rtl/ahe_ram.sv
// ----------------------------------------------------------------------------
// ahe_ram: generic single write, single read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module ahe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/ahe_code_checker.sv
// ----------------------------------------------------------------------------
// ahe_code_checker: scoreboard for the adaptive Huffman encoder
// Watches the symbol and code channels and keeps its own FGK tree. Each
// accepted symbol beat is coded against that tree, and the expected code is
// queued. Each code beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module ahe_code_checker (
  input  logic clk,
  input  logic rst,
  ahe_sym_if   sym,
  ahe_code_if  code,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ahe_pkg::CODE_MAX-1:0] bits;
    logic [ahe_pkg::LEN_W-1:0]    len;
    logic                         fresh;
    logic                         bad;
    logic                         ovf;
  } code_beat_t;

  code_beat_t code_q[$];

  // model tree
  logic [ahe_pkg::WEIGHT_BITS-1:0] tw[ahe_pkg::NODE_COUNT];
  int                              tpar[ahe_pkg::NODE_COUNT];
  bit                              tleaf[ahe_pkg::NODE_COUNT];
  int                              tkid[ahe_pkg::NODE_COUNT];
  int                              leaf_of[ahe_pkg::LETTERS];
  int                              nyt_pos;

  function automatic void tree_clear();
    for (int i = 0; i < ahe_pkg::NODE_COUNT; i++) begin
      tw[i] = '0; tpar[i] = 0; tleaf[i] = 0; tkid[i] = 0;
    end
    for (int i = 0; i < ahe_pkg::LETTERS; i++) leaf_of[i] = 0;
    tleaf[ahe_pkg::TOP] = 1;
    nyt_pos = ahe_pkg::TOP;
  endfunction

  function automatic void relink(int x);
    int c;
    if (tleaf[x]) begin
      if (x != nyt_pos && tkid[x] < ahe_pkg::LETTERS) leaf_of[tkid[x]] = x;
    end else begin
      c = tkid[x];
      if (c >= 1 && c < ahe_pkg::NODE_COUNT) begin
        tpar[c] = x;
        tpar[c-1] = x;
      end
    end
  endfunction

  function automatic void swap_pos(int a, int b);
    logic [ahe_pkg::WEIGHT_BITS-1:0] w;
    bit l;
    int k;
    bit na, nb;
    w = tw[a]; l = tleaf[a]; k = tkid[a];
    na = (a == nyt_pos); nb = (b == nyt_pos);
    tw[a] = tw[b]; tleaf[a] = tleaf[b]; tkid[a] = tkid[b];
    tw[b] = w; tleaf[b] = l; tkid[b] = k;
    if (na) nyt_pos = b;
    if (nb) nyt_pos = a;
    relink(a);
    relink(b);
  endfunction

  // root-to-node path, first bit most significant
  function automatic logic [63:0] path_bits(int q, output int n);
    logic [63:0] bits;
    int p, steps;
    bits = '0; n = 0; steps = 0;
    while (q != ahe_pkg::TOP && q < ahe_pkg::NODE_COUNT &&
           steps < ahe_pkg::NODE_COUNT) begin
      p = tpar[q];
      if (p >= ahe_pkg::NODE_COUNT) break;
      if (n < ahe_pkg::CODE_MAX) begin
        if (tkid[p] == q) bits[n] = 1'b1;
        n++;
      end
      q = p;
      steps++;
    end
    return bits;
  endfunction

  // leaf-to-root weight update with leader swap
  function automatic void bump_weights(int p);
    int steps, lead;
    steps = 0;
    while (p != ahe_pkg::TOP && p < ahe_pkg::NODE_COUNT &&
           steps < ahe_pkg::NODE_COUNT) begin
      lead = p;
      for (int i = p + 1; i < ahe_pkg::TOP; i++)
        if (tw[i] == tw[p] && i != tpar[p]) lead = i;
      if (lead != p) begin
        swap_pos(p, lead);
        p = lead;
      end
      tw[p] = tw[p] + 1'b1;
      p = tpar[p];
      steps++;
    end
    tw[ahe_pkg::TOP] = tw[ahe_pkg::TOP] + 1'b1;
  endfunction

  function automatic code_beat_t encode_symbol(logic [7:0] b);
    code_beat_t r;
    int idx, len, klen, esc, n;
    logic [63:0] c;
    r = '{default: '0};
    if (b >= ahe_pkg::UPPER_LO && b <= ahe_pkg::UPPER_HI) idx = b - ahe_pkg::UPPER_LO;
    else if (b >= ahe_pkg::LOWER_LO && b <= ahe_pkg::LOWER_HI)
      idx = b - ahe_pkg::LOWER_BASE;
    else idx = ahe_pkg::LETTERS;
    if (idx >= ahe_pkg::LETTERS) begin
      r.bad = 1'b1;
      return r;
    end
    r.ovf = (tw[ahe_pkg::TOP] == '1);
    r.fresh = (leaf_of[idx] == 0);
    if (!r.fresh) begin
      c = path_bits(leaf_of[idx], len);
    end else begin
      c = path_bits(nyt_pos, len);
      if (idx < ahe_pkg::ESC_SPLIT) begin
        esc = idx; klen = ahe_pkg::ESC_LONG;
      end else begin
        esc = idx - ahe_pkg::ESC_OFFSET; klen = ahe_pkg::ESC_SHORT;
      end
      c = (c << klen) | 64'(esc);
      len += klen;
      if (len > ahe_pkg::CODE_MAX) len = ahe_pkg::CODE_MAX;
    end
    r.bits = c[ahe_pkg::CODE_MAX-1:0];
    r.len = ahe_pkg::LEN_W'(len);
    if (r.ovf) return r;
    if (!r.fresh) begin
      bump_weights(leaf_of[idx]);
    end else if (nyt_pos >= 2 && nyt_pos < ahe_pkg::NODE_COUNT) begin
      // split the NYT leaf into a new NYT and the letter leaf
      n = nyt_pos;
      tleaf[n] = 0;       tkid[n] = n - 1;
      tleaf[n-1] = 1;     tkid[n-1] = idx;  tw[n-1] = '0; tpar[n-1] = n;
      tleaf[n-2] = 1;     tkid[n-2] = 0;    tw[n-2] = '0; tpar[n-2] = n;
      nyt_pos = n - 2;
      leaf_of[idx] = n - 1;
      bump_weights(n - 1);
    end
    return r;
  endfunction

  // compare code beats, then queue predictions for symbol beats
  always @(posedge clk) begin
    code_beat_t want;
    if (rst) begin
      tree_clear();
      code_q.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (code.valid && code.ready) begin
        if (code_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: code beat with nothing expected: bits=%h len=%0d",
                     $realtime, code.code_bits, code.code_length);
          fail_count <= fail_count + 1;
        end else begin
          want = code_q.pop_front();
          if (code.code_bits !== want.bits || code.code_length !== want.len ||
              code.new_letter !== want.fresh || code.bad_symbol !== want.bad ||
              code.weight_overflow !== want.ovf) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp bits=%h len=%0d new=%b bad=%b ovf=%b",
                       $realtime, want.bits, want.len, want.fresh, want.bad,
                       want.ovf, " got bits=%h len=%0d new=%b bad=%b ovf=%b",
                       code.code_bits, code.code_length, code.new_letter,
                       code.bad_symbol, code.weight_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (sym.valid && sym.ready)
        code_q.insert(code_q.size(), encode_symbol(sym.symbol_byte));
      outstanding <= code_q.size();
    end
  end
endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the adaptive Huffman encoder
// Feeds directed edge bytes, then a skewed random letter stream with noise,
// in bursts; the code side stalls on its own pattern. The checker predicts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  bit   stim_done;
  logic [7:0] stim_q[$];

  ahe_sym_if  sym();
  ahe_code_if code();

  adaptive_huffman_encoder_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .sym  (sym),
    .code (code)
  );

  ahe_code_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .sym         (sym),
    .code        (code),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("FAIL");
    $finish;
  end

  // code-side stall pattern, switching between four random modes
  initial begin
    int mode, cnt;
    code.ready = 1'b0;
    mode = 0; cnt = 0;
    forever begin
      @(negedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(3);
        cnt = 64;
      end
      cnt--;
      case (mode)
        0: code.ready <= 1'b1;
        1: code.ready <= ($urandom_range(1) == 1);
        2: code.ready <= ($urandom_range(7) == 0);
        default: code.ready <= (cnt[3:0] < 4'd10);
      endcase
    end
  end

  // build stimulus: directed bytes, then random letters and noise
  initial begin
    logic [7:0] hot[6];
    int sel;
    stim_q = '{8'd65, 8'd65, 8'd90, 8'd97, 8'd122, 8'd110, 8'd111, 8'd122,
               8'd0, 8'd255, 8'd64, 8'd91, 8'd96, 8'd123, 8'd90, 8'd65,
               8'd111, 8'd110, 8'd128, 8'd127, 8'd97, 8'd65};
    for (int i = 0; i < 6; i++) hot[i] = 8'(ahe_pkg::UPPER_LO + $urandom_range(25));
    for (int i = 0; i < 1650; i++) begin
      if (i == 800) begin
        // every letter once, so the node store fills
        for (int l = 0; l < 26; l++)
          stim_q.insert(stim_q.size(), 8'(ahe_pkg::UPPER_LO + l));
        for (int l = 0; l < 26; l++)
          stim_q.insert(stim_q.size(), 8'(ahe_pkg::LOWER_LO + l));
      end
      sel = $urandom_range(99);
      if (sel < 60) stim_q.insert(stim_q.size(), hot[$urandom_range(5)]);
      else if (sel < 90) begin
        if ($urandom_range(1))
          stim_q.insert(stim_q.size(), 8'(ahe_pkg::UPPER_LO + $urandom_range(25)));
        else
          stim_q.insert(stim_q.size(), 8'(ahe_pkg::LOWER_LO + $urandom_range(25)));
      end else stim_q.insert(stim_q.size(), 8'($urandom_range(255)));
    end
  end

  // symbol sender in bursts with gaps
  initial begin
    int idx, burst, gap;
    rst = 1'b1;
    sym.valid = 1'b0;
    sym.symbol_byte = '0;
    stim_done = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idx = 0;
    burst = $urandom_range(1, 20);
    gap = 0;
    while (idx < stim_q.size()) begin
      @(negedge clk);
      if (gap > 0) begin
        sym.valid <= 1'b0;
        sym.symbol_byte <= 8'($urandom_range(255));
        gap--;
      end else begin
        sym.valid <= 1'b1;
        sym.symbol_byte <= stim_q[idx];
      end
      @(posedge clk);
      if (sym.valid && sym.ready) begin
        idx++;
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 300);
        end
      end
    end
    @(negedge clk);
    sym.valid <= 1'b0;
    stim_done = 1;
  end

  // verdict
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8000) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
